// ===== design/zwaf_pkg.sv =====
`timescale 1ns / 1ps
// Shared codes and constants for the zoom window aspect fit block.
// Used by every module of the block; depends on nothing.
package zwaf_pkg;

    localparam logic [1:0] ASPECT_WIDER  = 2'd0;
    localparam logic [1:0] ASPECT_TALLER = 2'd1;
    localparam logic [1:0] ASPECT_MATCH  = 2'd2;

    localparam int TOL_DEN = 100;
    localparam int OUT_USER_BITS = 3;

    // Position of the control flags in the payload carried along the divider row.
    localparam int PAY_ALIGN = 0;
    localparam int PAY_USE_H = 1;
    localparam int PAY_USE_W = 2;
    localparam int PAY_BAD   = 3;
    localparam int PAY_KIND  = 4;
    localparam int PAY_CTRL  = 6;

endpackage

// ===== design/zwaf_front.sv =====
`timescale 1ns / 1ps
// Front end: products, aspect decision and divider operand selection, two stages.
// Depends on zwaf_pkg.
module zwaf_front #(
    parameter int N = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    in_valid,
    input  logic [8*N-1:0]          in_data,
    input  logic                    in_sat,
    output logic                    out_valid,
    output logic [N-1:0]            rem_w,
    output logic [N-1:0]            low_w,
    output logic [N-1:0]            den_w,
    output logic [N-1:0]            rem_h,
    output logic [N-1:0]            low_h,
    output logic [N-1:0]            den_h,
    output logic [4*N+zwaf_pkg::PAY_CTRL-1:0] pay
);
    import zwaf_pkg::*;

    localparam int PW = 4 * N + PAY_CTRL;
    localparam int DW = 2 * N + 7;

    logic [N-1:0] iw, ih, cl, ct, cw, ch, snw, snh, rw, rh;

    logic           v1_reg;
    logic [2*N-1:0] p_ihcw_reg, p_iwch_reg, p_cwch_reg, p_cwrw_reg, p_chrh_reg;
    logic [N-1:0]   iw_reg, ih_reg, cl_reg, ct_reg, cw_reg, ch_reg, snw_reg, snh_reg;
    logic           sat_reg;

    logic           v2_reg;
    logic [N-1:0]   rem_w_reg, low_w_reg, den_w_reg, rem_h_reg, low_h_reg, den_h_reg;
    logic [PW-1:0]  pay_reg;

    logic           bad0, wider, taller, scale, bad1;
    logic [DW-1:0]  diff_wide, diff_tall, bd;
    logic [2*N-1:0] num_w_next, num_h_next;
    logic [N-1:0]   den_w_next, den_h_next;
    logic [1:0]     kind;
    logic [PW-1:0]  pay_next;

    assign iw  = in_data[0*N +: N];
    assign ih  = in_data[1*N +: N];
    assign cl  = in_data[2*N +: N];
    assign ct  = in_data[3*N +: N];
    assign cw  = in_data[4*N +: N];
    assign ch  = in_data[5*N +: N];
    assign snw = in_data[6*N +: N];
    assign snh = in_data[7*N +: N];
    assign rw  = (iw > snw) ? snw : iw;
    assign rh  = (ih > snh) ? snh : ih;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_ihcw_reg <= (2*N)'(ih) * (2*N)'(cw);
            p_iwch_reg <= (2*N)'(iw) * (2*N)'(ch);
            p_cwch_reg <= (2*N)'(cw) * (2*N)'(ch);
            p_cwrw_reg <= (2*N)'(cw) * (2*N)'(rw);
            p_chrh_reg <= (2*N)'(ch) * (2*N)'(rh);
            iw_reg  <= iw;
            ih_reg  <= ih;
            cl_reg  <= cl;
            ct_reg  <= ct;
            cw_reg  <= cw;
            ch_reg  <= ch;
            snw_reg <= snw;
            snh_reg <= snh;
            sat_reg <= in_sat;
        end
    end

    always_comb
    begin
        bad0      = (cw_reg == '0) || (ch_reg == '0);
        diff_wide = DW'(p_iwch_reg - p_ihcw_reg) * DW'(TOL_DEN);
        diff_tall = DW'(p_ihcw_reg - p_iwch_reg) * DW'(TOL_DEN);
        bd        = DW'(p_cwch_reg);
        wider     = !bad0 && (p_iwch_reg > p_ihcw_reg) && (diff_wide > bd);
        taller    = !bad0 && !wider && (p_ihcw_reg > p_iwch_reg) && (diff_tall > bd);
        bad1      = (snw_reg == '0) || (snh_reg == '0);
        scale     = !bad0 && !wider && !taller && sat_reg && !bad1;

        num_w_next = '0;
        den_w_next = N'(1);
        num_h_next = '0;
        den_h_next = N'(1);
        if (taller)
        begin
            num_w_next = p_iwch_reg;
            den_w_next = ih_reg;
        end
        else if (scale)
        begin
            num_w_next = p_cwrw_reg;
            den_w_next = snw_reg;
        end
        if (wider)
        begin
            num_h_next = p_ihcw_reg;
            den_h_next = iw_reg;
        end
        else if (scale)
        begin
            num_h_next = p_chrh_reg;
            den_h_next = snh_reg;
        end

        if (wider)
            kind = ASPECT_WIDER;
        else if (taller)
            kind = ASPECT_TALLER;
        else
            kind = ASPECT_MATCH;

        pay_next = {cl_reg, ct_reg, cw_reg, ch_reg, kind,
                    bad0 || (!wider && !taller && sat_reg && bad1),
                    taller || scale, wider || scale, wider || taller};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_w_reg <= num_w_next[2*N-1:N];
            low_w_reg <= num_w_next[N-1:0];
            den_w_reg <= den_w_next;
            rem_h_reg <= num_h_next[2*N-1:N];
            low_h_reg <= num_h_next[N-1:0];
            den_h_reg <= den_h_next;
            pay_reg   <= pay_next;
        end
    end

    assign out_valid = v2_reg;
    assign rem_w     = rem_w_reg;
    assign low_w     = low_w_reg;
    assign den_w     = den_w_reg;
    assign rem_h     = rem_h_reg;
    assign low_h     = low_h_reg;
    assign den_h     = den_h_reg;
    assign pay       = pay_reg;

endmodule

// ===== design/zwaf_div_cell.sv =====
`timescale 1ns / 1ps
// One cell of the divider row: one restoring step for the width and height lanes.
// Depends on zwaf_pkg.
module zwaf_div_cell #(
    parameter int N  = 16,
    parameter int PW = 70
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  logic [N-1:0]  in_rem_w,
    input  logic [N-1:0]  in_low_w,
    input  logic [N-1:0]  in_q_w,
    input  logic [N-1:0]  in_den_w,
    input  logic [N-1:0]  in_rem_h,
    input  logic [N-1:0]  in_low_h,
    input  logic [N-1:0]  in_q_h,
    input  logic [N-1:0]  in_den_h,
    input  logic [PW-1:0] in_pay,
    output logic          out_valid,
    output logic [N-1:0]  out_rem_w,
    output logic [N-1:0]  out_low_w,
    output logic [N-1:0]  out_q_w,
    output logic [N-1:0]  out_den_w,
    output logic [N-1:0]  out_rem_h,
    output logic [N-1:0]  out_low_h,
    output logic [N-1:0]  out_q_h,
    output logic [N-1:0]  out_den_h,
    output logic [PW-1:0] out_pay
);
    import zwaf_pkg::*;

    logic          valid_reg;
    logic [N-1:0]  rem_w_reg, low_w_reg, q_w_reg, den_w_reg;
    logic [N-1:0]  rem_h_reg, low_h_reg, q_h_reg, den_h_reg;
    logic [PW-1:0] pay_reg;
    logic [N:0]    r2_w, r2_h, d_w, d_h;
    logic          ge_w, ge_h;

    always_comb
    begin
        r2_w = {in_rem_w, in_low_w[N-1]};
        r2_h = {in_rem_h, in_low_h[N-1]};
        ge_w = r2_w >= {1'b0, in_den_w};
        ge_h = r2_h >= {1'b0, in_den_h};
        d_w  = r2_w - {1'b0, in_den_w};
        d_h  = r2_h - {1'b0, in_den_h};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_w_reg <= ge_w ? d_w[N-1:0] : r2_w[N-1:0];
            rem_h_reg <= ge_h ? d_h[N-1:0] : r2_h[N-1:0];
            low_w_reg <= {in_low_w[N-2:0], 1'b0};
            low_h_reg <= {in_low_h[N-2:0], 1'b0};
            q_w_reg   <= {in_q_w[N-2:0], ge_w};
            q_h_reg   <= {in_q_h[N-2:0], ge_h};
            den_w_reg <= in_den_w;
            den_h_reg <= in_den_h;
            pay_reg   <= in_pay;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem_w = rem_w_reg;
    assign out_low_w = low_w_reg;
    assign out_q_w   = q_w_reg;
    assign out_den_w = den_w_reg;
    assign out_rem_h = rem_h_reg;
    assign out_low_h = low_h_reg;
    assign out_q_h   = q_h_reg;
    assign out_den_h = den_h_reg;
    assign out_pay   = pay_reg;

endmodule

// ===== design/zwaf_back.sv =====
`timescale 1ns / 1ps
// Back end: alignment, centering and saturation into the output register.
// Depends on zwaf_pkg.
module zwaf_back #(
    parameter int N = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    in_valid,
    input  logic [N-1:0]            q_w,
    input  logic [N-1:0]            q_h,
    input  logic [4*N+zwaf_pkg::PAY_CTRL-1:0] pay,
    output logic                    out_valid,
    output logic [4*N-1:0]          out_data,
    output logic [zwaf_pkg::OUT_USER_BITS-1:0] out_user
);
    import zwaf_pkg::*;

    logic [N-1:0] cl, ct, cw, ch, w, h, l, t, half_w, half_h;
    logic [N:0]   l_sum, t_sum;
    logic         valid_reg;
    logic [4*N-1:0] data_reg;
    logic [OUT_USER_BITS-1:0] user_reg;

    always_comb
    begin
        ch = pay[PAY_CTRL +: N];
        cw = pay[PAY_CTRL + N +: N];
        ct = pay[PAY_CTRL + 2*N +: N];
        cl = pay[PAY_CTRL + 3*N +: N];
        w  = cw;
        h  = ch;
        if (pay[PAY_USE_W])
            w = pay[PAY_ALIGN] ? {q_w[N-1:1], 1'b0} : q_w;
        if (pay[PAY_USE_H])
            h = pay[PAY_ALIGN] ? {q_h[N-1:1], 1'b0} : q_h;
        half_w = (cw - w) >> 1;
        half_h = (ch - h) >> 1;
        l_sum = {1'b0, cl} + {1'b0, half_w};
        t_sum = {1'b0, ct} + {1'b0, half_h};
        l = l_sum[N] ? '1 : l_sum[N-1:0];
        t = t_sum[N] ? '1 : t_sum[N-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= {h, w, t, l};
            user_reg <= {pay[PAY_BAD], pay[PAY_KIND +: 2]};
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;
    assign out_user  = user_reg;

endmodule

// ===== design/zoom_window_aspect_fit.sv =====
`timescale 1ns / 1ps
// Top level of the zoom window aspect fit block.
// Depends on zwaf_pkg, zwaf_front, zwaf_div_cell and zwaf_back.
//
// Each slave transaction carries the image size, the crop rectangle and the
// sensor size in s_tdata and the SAT flag in s_tuser. Each master transaction
// returns one window of interest in m_tdata with the aspect case and the bad
// size flag in m_tuser, in the order the inputs arrived.
// The block takes one transaction per cycle while the receiver does not stall.
// The pipeline has one stage of products, one stage of aspect decision, one divider
// cell per quotient bit and one output register.
// The whole pipeline advances together. When the receiver stalls with a
// result waiting, s_tready falls and every stage holds its contents.
// Reset clears all valid flags, so no result is presented after reset until
// a new input is accepted.
module zoom_window_aspect_fit #(
    parameter int COORD_BITS = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    // img_width, img_height, crop_left, crop_top, crop_width, crop_height,
    // sensor_width, sensor_height.
    input  logic [8*COORD_BITS-1:0] s_tdata,
    // sat_mode.
    input  logic                    s_tuser,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    // woi_left, woi_top, woi_width, woi_height.
    output logic [4*COORD_BITS-1:0] m_tdata,
    // aspect_case (2 bits), bad_size.
    output logic [zwaf_pkg::OUT_USER_BITS-1:0] m_tuser
);
    import zwaf_pkg::*;

    localparam int N  = COORD_BITS;
    localparam int PW = 4 * N + PAY_CTRL;

    logic          en;
    logic          v    [0:N];
    logic [N-1:0]  rem_w [0:N];
    logic [N-1:0]  low_w [0:N];
    logic [N-1:0]  q_w   [0:N];
    logic [N-1:0]  den_w [0:N];
    logic [N-1:0]  rem_h [0:N];
    logic [N-1:0]  low_h [0:N];
    logic [N-1:0]  q_h   [0:N];
    logic [N-1:0]  den_h [0:N];
    logic [PW-1:0] pay   [0:N];

    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;
    assign q_w[0]   = '0;
    assign q_h[0]   = '0;

    zwaf_front #(.N(N)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_tvalid),
        .in_data   (s_tdata),
        .in_sat    (s_tuser),
        .out_valid (v[0]),
        .rem_w     (rem_w[0]),
        .low_w     (low_w[0]),
        .den_w     (den_w[0]),
        .rem_h     (rem_h[0]),
        .low_h     (low_h[0]),
        .den_h     (den_h[0]),
        .pay       (pay[0])
    );

    for (genvar i = 0; i < N; i++)
    begin : g_cell
        zwaf_div_cell #(.N(N), .PW(PW)) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (v[i]),
            .in_rem_w  (rem_w[i]),
            .in_low_w  (low_w[i]),
            .in_q_w    (q_w[i]),
            .in_den_w  (den_w[i]),
            .in_rem_h  (rem_h[i]),
            .in_low_h  (low_h[i]),
            .in_q_h    (q_h[i]),
            .in_den_h  (den_h[i]),
            .in_pay    (pay[i]),
            .out_valid (v[i+1]),
            .out_rem_w (rem_w[i+1]),
            .out_low_w (low_w[i+1]),
            .out_q_w   (q_w[i+1]),
            .out_den_w (den_w[i+1]),
            .out_rem_h (rem_h[i+1]),
            .out_low_h (low_h[i+1]),
            .out_q_h   (q_h[i+1]),
            .out_den_h (den_h[i+1]),
            .out_pay   (pay[i+1])
        );
    end

    zwaf_back #(.N(N)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v[N]),
        .q_w       (q_w[N]),
        .q_h       (q_h[N]),
        .pay       (pay[N]),
        .out_valid (m_tvalid),
        .out_data  (m_tdata),
        .out_user  (m_tuser)
    );

endmodule

// ===== design/zwaf_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the zoom window aspect fit block and its bind.
// Depends on zwaf_pkg and on the ports of zoom_window_aspect_fit.
module zwaf_checker #(
    parameter int COORD_BITS = 16
) (
    input logic                    clk,
    input logic                    rst_n,
    input logic                    s_tready,
    input logic                    m_tvalid,
    input logic                    m_tready,
    input logic [4*COORD_BITS-1:0] m_tdata,
    input logic [zwaf_pkg::OUT_USER_BITS-1:0] m_tuser
);
    import zwaf_pkg::*;

    a_ready_follows_output: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready == (!m_tvalid || m_tready))
        else $error("Input ready does not track the output stall.");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("A stalled result transaction changed.");

    a_case_legal: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser[1:0] == ASPECT_WIDER || m_tuser[1:0] == ASPECT_TALLER
                      || m_tuser[1:0] == ASPECT_MATCH))
        else $error("Illegal aspect case code.");

    a_bad_is_match: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[2]) |-> (m_tuser[1:0] == ASPECT_MATCH))
        else $error("A bad size result reports a non-matching aspect case.");

endmodule

bind zoom_window_aspect_fit zwaf_checker #(.COORD_BITS(COORD_BITS)) u_zwaf_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ===== sim/tb_zoom_window_aspect_fit.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the zoom window aspect fit block.
// Depends on zwaf_pkg and zoom_window_aspect_fit; predicts each window in a scoreboard class.
module tb_zoom_window_aspect_fit;
    import zwaf_pkg::*;

    localparam int CB = 16;
    localparam int N_RANDOM = 750;
    localparam int LATENCY = CB + 3;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [CB-1:0] sensor_height;
        logic [CB-1:0] sensor_width;
        logic [CB-1:0] crop_height;
        logic [CB-1:0] crop_width;
        logic [CB-1:0] crop_top;
        logic [CB-1:0] crop_left;
        logic [CB-1:0] img_height;
        logic [CB-1:0] img_width;
    } crop_req_t;

    typedef struct packed {
        logic [CB-1:0] woi_height;
        logic [CB-1:0] woi_width;
        logic [CB-1:0] woi_top;
        logic [CB-1:0] woi_left;
    } woi_t;

    typedef struct {
        woi_t       woi;
        logic [1:0] aspect_case;
        logic       bad_size;
    } window_t;

    class window_scoreboard;
        window_t pending[$];
        int      errors;

        function bit ratio_short(longint unsigned a, longint unsigned b,
                                 longint unsigned c, longint unsigned d);
            longint unsigned lhs;
            longint unsigned rhs;
            lhs = a * d;
            rhs = c * b;
            if (rhs <= lhs)
                return 0;
            return (rhs - lhs) > (b * d) / TOL_DEN;
        endfunction

        function longint unsigned clip(longint unsigned v);
            return v > 65535 ? 65535 : v;
        endfunction

        function void note_request(crop_req_t r, logic sat);
            longint unsigned iw, ih, cl, ct, cw, ch, snw, snh, l, t, w, h, rw, rh;
            window_t e;
            iw = 64'(r.img_width);   ih = 64'(r.img_height);
            cl = 64'(r.crop_left);   ct = 64'(r.crop_top);
            cw = 64'(r.crop_width);  ch = 64'(r.crop_height);
            snw = 64'(r.sensor_width); snh = 64'(r.sensor_height);
            l = cl; t = ct; w = cw; h = ch;
            e.aspect_case = ASPECT_MATCH;
            e.bad_size = 1'b0;
            if (cw == 0 || ch == 0) begin
                e.bad_size = 1'b1;
            end else if (ratio_short(ih, ch, iw, cw)) begin
                e.aspect_case = ASPECT_WIDER;
                h = ((ih * cw) / iw) & ~64'd1;
                t = ct + (ch - h) / 2;
            end else if (ratio_short(iw, cw, ih, ch)) begin
                e.aspect_case = ASPECT_TALLER;
                w = ((iw * ch) / ih) & ~64'd1;
                l = cl + (cw - w) / 2;
            end else if (sat) begin
                if (snw == 0 || snh == 0) begin
                    e.bad_size = 1'b1;
                end else begin
                    rw = iw > snw ? snw : iw;
                    rh = ih > snh ? snh : ih;
                    w = (cw * rw) / snw;
                    h = (ch * rh) / snh;
                    l = cl + (cw - w) / 2;
                    t = ct + (ch - h) / 2;
                end
            end
            e.woi.woi_left = CB'(clip(l));
            e.woi.woi_top = CB'(clip(t));
            e.woi.woi_width = CB'(clip(w));
            e.woi.woi_height = CB'(clip(h));
            pending.push_back(e);
        endfunction

        function void check_window(woi_t got, logic [OUT_USER_BITS-1:0] user);
            window_t e;
            if (pending.size() == 0) begin
                $error("unexpected result transaction");
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.woi_left !== e.woi.woi_left) begin
                $error("woi_left expected %0d actual %0d", e.woi.woi_left, got.woi_left);
                errors++;
            end
            if (got.woi_top !== e.woi.woi_top) begin
                $error("woi_top expected %0d actual %0d", e.woi.woi_top, got.woi_top);
                errors++;
            end
            if (got.woi_width !== e.woi.woi_width) begin
                $error("woi_width expected %0d actual %0d", e.woi.woi_width, got.woi_width);
                errors++;
            end
            if (got.woi_height !== e.woi.woi_height) begin
                $error("woi_height expected %0d actual %0d", e.woi.woi_height,
                       got.woi_height);
                errors++;
            end
            if (user[1:0] !== e.aspect_case) begin
                $error("aspect_case expected %0d actual %0d", e.aspect_case, user[1:0]);
                errors++;
            end
            if (user[2] !== e.bad_size) begin
                $error("bad_size expected %0d actual %0d", e.bad_size, user[2]);
                errors++;
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [8*CB-1:0]       s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [4*CB-1:0]       m_tdata;
    logic [OUT_USER_BITS-1:0] m_tuser;

    window_scoreboard sb;
    longint cycles;
    bit     stimulus_done;
    int     burst_left;

    zoom_window_aspect_fit #(.COORD_BITS(CB)) dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    initial
    begin
        sb = new();
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        m_tready = 1'b0;
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
    end

    // The receiver alternates between stretches of always-ready and random stalls.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (burst_left > 0) begin
                burst_left <= burst_left - 1;
                m_tready <= 1'b1;
            end else if ($urandom_range(0, 40) == 0) begin
                burst_left <= $urandom_range(10, 60);
                m_tready <= 1'b1;
            end else begin
                m_tready <= ($urandom_range(0, 3) != 0);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n) begin
            if (s_tvalid && s_tready)
                sb.note_request(crop_req_t'(s_tdata), s_tuser);
            if (m_tvalid && m_tready)
                sb.check_window(woi_t'(m_tdata), m_tuser);
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic send_request(crop_req_t r, logic sat);
        s_tvalid <= 1'b1;
        s_tdata <= r;
        s_tuser <= sat;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic pause_sender(int n);
        s_tvalid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    function automatic logic [CB-1:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 16'd0;
            1: return 16'hFFFF;
            2: return CB'($urandom_range(0, 64));
            default: return CB'($urandom);
        endcase
    endfunction

    // Mostly builds crops near the image aspect, so the match and SAT paths are reached.
    function automatic crop_req_t rand_request();
        crop_req_t r;
        int k;
        r.img_width = rand_coord();
        r.img_height = rand_coord();
        r.crop_left = rand_coord();
        r.crop_top = rand_coord();
        r.sensor_width = rand_coord();
        r.sensor_height = rand_coord();
        k = int'($urandom_range(1, 16));
        case ($urandom_range(0, 3))
            0: begin
                r.crop_width = rand_coord();
                r.crop_height = rand_coord();
            end
            1: begin
                r.img_width = CB'($urandom_range(1, 4000));
                r.img_height = CB'($urandom_range(1, 4000));
                r.crop_width = CB'(int'(r.img_width) * k / 16);
                r.crop_height = CB'(int'(r.img_height) * k / 16
                                    + int'($urandom_range(0, 2)));
            end
            default: begin
                r.img_width = CB'($urandom_range(1, 4000));
                r.img_height = CB'($urandom_range(1, 4000));
                r.crop_width = CB'(int'(r.img_width) * k / 16);
                r.crop_height = CB'(int'(r.img_height) * k / 16);
            end
        endcase
        return r;
    endfunction

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 5) @(posedge clk);
    endtask

    crop_req_t directed[$];
    logic      directed_sat[$];

    task automatic add_directed(int iw, int ih, int cl, int ct, int cw, int ch,
                                int snw, int snh, logic sat);
        crop_req_t r;
        r = {16'(snh), 16'(snw), 16'(ch), 16'(cw), 16'(ct), 16'(cl), 16'(ih), 16'(iw)};
        directed.push_back(r);
        directed_sat.push_back(sat);
    endtask

    initial
    begin
        int gap;
        int burst;
        int sent;
        cycles = 0;
        burst_left = 0;
        stimulus_done = 0;
        @(posedge rst_n);
        @(posedge clk);
        add_directed(1920, 1080, 0, 0, 4000, 1080, 4000, 3000, 0);
        add_directed(1920, 1080, 10, 20, 1000, 3000, 4000, 3000, 0);
        add_directed(1920, 1080, 100, 50, 1920, 1080, 4000, 3000, 0);
        add_directed(1920, 1080, 100, 50, 1920, 1080, 1000, 3000, 1);
        add_directed(1920, 1080, 100, 50, 1920, 1080, 0, 3000, 1);
        add_directed(1920, 1080, 100, 50, 1920, 1080, 4000, 0, 1);
        add_directed(1920, 1080, 5, 5, 0, 1080, 4000, 3000, 0);
        add_directed(1920, 1080, 5, 5, 1920, 0, 4000, 3000, 1);
        add_directed(0, 1080, 5, 5, 100, 100, 4000, 3000, 0);
        add_directed(1920, 0, 5, 5, 100, 100, 4000, 3000, 0);
        add_directed(0, 0, 5, 5, 100, 100, 4000, 3000, 1);
        add_directed(65535, 1, 65535, 65535, 65535, 65535, 65535, 65535, 0);
        add_directed(1, 65535, 65535, 65535, 65535, 65535, 65535, 65535, 0);
        add_directed(65535, 65535, 65535, 65535, 65535, 65535, 65535, 65535, 1);
        add_directed(65535, 65535, 65535, 65535, 65535, 65535, 1, 1, 1);
        add_directed(0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_directed(101, 100, 0, 0, 100, 100, 50, 50, 1);
        add_directed(102, 100, 0, 0, 100, 100, 50, 50, 1);
        add_directed(100, 102, 0, 0, 100, 100, 50, 50, 0);
        foreach (directed[i])
            send_request(directed[i], directed_sat[i]);
        drain();
        sent = 0;
        while (sent < N_RANDOM) begin
            burst = int'($urandom_range(1, 30));
            for (int j = 0; j < burst && sent < N_RANDOM; j++) begin
                send_request(rand_request(), 1'($urandom_range(0, 1)));
                sent++;
            end
            gap = $urandom_range(0, 3) == 0 ? 0 : int'($urandom_range(1, 8));
            if (gap != 0)
                pause_sender(gap);
            if (sent >= N_RANDOM / 2 && sent - burst < N_RANDOM / 2)
                drain();
        end
        drain();
        if (sb.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
